// ----- rtl/core/isp_pkg.sv -----
// shared types and constants of the intensity stretch pixel mapper
package isp_pkg;

  // default viewport size
  localparam int unsigned VIEW_WIDTH_DEF  = 1024;
  localparam int unsigned VIEW_HEIGHT_DEF = 1024;

  // display index constants
  localparam logic [7:0] IDX_MAX     = 8'd255;
  localparam logic [7:0] CHECKER_IDX = 8'd30;
  localparam logic [7:0] REVERSE_MASK = 8'hFF;

  // arithmetic constants
  localparam int unsigned FIX_FRAC   = 26;
  localparam int unsigned DIV_INT    = 8;
  localparam int unsigned DIV_STAGES = DIV_INT + FIX_FRAC;
  localparam int unsigned SQ_STAGES  = 24;
  localparam logic [30:0] LOG_COEF   = 31'd1287863541;
  localparam logic [15:0] SQRT_SCALE = 16'd65025;

  // transfer function codes
  typedef enum logic [1:0] {
    MODE_LINEAR = 2'd0,
    MODE_SQRT   = 2'd1,
    MODE_LOG    = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LEVEL_LOW  = 2'd0,
    REG_LEVEL_HIGH = 2'd1,
    REG_MODE       = 2'd2,
    REG_REVERSE    = 2'd3
  } reg_idx_e;

  // per pixel side information carried along the pipe
  typedef struct packed {
    logic       spec;
    logic [7:0] spec_idx;
    logic [7:0] sqrt_k;
  } side_t;

  // divider / square root stage
  typedef struct packed {
    logic                    valid;
    side_t                   side;
    logic [31:0]             r;
    logic [39:0]             rem;
    logic [DIV_STAGES-1:0]   q;
    logic [47:0]             rhs;
    logic [15:0]             k2;
  } div_t;

  // logarithm stage
  typedef struct packed {
    logic                  valid;
    side_t                 side;
    logic [7:0]            lin;
    logic [1:0]            n;
    logic [26:0]           m;
    logic [SQ_STAGES-1:0]  frac;
  } log_t;

  // after the coefficient multiply
  typedef struct packed {
    logic       valid;
    side_t      side;
    logic [7:0] lin;
    logic [8:0] lidx;
  } coef_t;

endpackage

// ----- rtl/core/intensity_stretch_pixel_mapper.sv -----
// top level of the intensity stretch pixel mapper
//
// channel  | handshake                   | payload
// ---------+-----------------------------+---------------------------------------
// pixel in | start & !busy               | sample_i blank_i outside_i column_i row_i
// result   | result_valid_o, one cycle   | pixel_index_o
// config   | cfg_valid_i & cfg_ready_o   | cfg_index_i cfg_data_i
//
// one pixel per clock; each pixel passes the front stages, the 34 stage divider
// and the 24 squaring stages of the log stretch before the output register
// busy and cfg_ready_o are tied off, the pipe never stalls
// reset clears valid bits and loads the register defaults
module intensity_stretch_pixel_mapper import isp_pkg::*; #(
  parameter int unsigned VIEW_WIDTH  = VIEW_WIDTH_DEF,
  parameter int unsigned VIEW_HEIGHT = VIEW_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] sample_i,
  input  logic        blank_i,
  input  logic        outside_i,
  input  logic [9:0]  column_i,
  input  logic [9:0]  row_i,
  output logic        result_valid_o,
  output logic [7:0]  pixel_index_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] level_low_q, level_high_q;
  mode_e       mode_q;
  logic        reverse_q;
  div_t        front_s, div_s;
  coef_t       coef_s;
  logic        result_valid_q;
  logic [7:0]  pixel_index_q, idx_d;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_low_q  <= 32'd0;
      level_high_q <= 32'd65536;
      mode_q       <= MODE_LINEAR;
      reverse_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_LEVEL_LOW:  level_low_q  <= cfg_data_i;
        REG_LEVEL_HIGH: level_high_q <= cfg_data_i;
        REG_MODE:       mode_q       <= mode_e'(cfg_data_i[1:0]);
        REG_REVERSE:    reverse_q    <= cfg_data_i[0];
      endcase
    end
  end

  isp_front #(
    .VIEW_WIDTH  (VIEW_WIDTH),
    .VIEW_HEIGHT (VIEW_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start & ~busy),
    .sample_i     (sample_i),
    .blank_i      (blank_i),
    .outside_i    (outside_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .level_low_i  (level_low_q),
    .level_high_i (level_high_q),
    .mode_i       (mode_q),
    .stage_o      (front_s)
  );

  isp_divsqrt u_divsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (front_s),
    .stage_o (div_s)
  );

  isp_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (div_s),
    .stage_o (coef_s)
  );

  // final selection and reversal
  always_comb begin
    if (coef_s.side.spec) begin
      idx_d = coef_s.side.spec_idx;
    end else begin
      unique case (mode_q)
        MODE_SQRT: idx_d = coef_s.side.sqrt_k;
        MODE_LOG:  idx_d = coef_s.lidx[8] ? IDX_MAX : coef_s.lidx[7:0];
        default:   idx_d = coef_s.lin;
      endcase
    end
    if (reverse_q) begin
      idx_d = idx_d ^ REVERSE_MASK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= coef_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_index_q <= idx_d;
  end

  assign result_valid_o = result_valid_q;
  assign pixel_index_o  = pixel_index_q;

endmodule

// ----- rtl/core/isp_front.sv -----
// front stages: classification, differences and divider operands
module isp_front import isp_pkg::*; #(
  parameter int unsigned VIEW_WIDTH  = VIEW_WIDTH_DEF,
  parameter int unsigned VIEW_HEIGHT = VIEW_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] sample_i,
  input  logic        blank_i,
  input  logic        outside_i,
  input  logic [9:0]  column_i,
  input  logic [9:0]  row_i,
  input  logic [31:0] level_low_i,
  input  logic [31:0] level_high_i,
  input  mode_e       mode_i,
  output div_t        stage_o
);

  logic        s0_valid_q;
  side_t       s0_side_q, s0_side_d;
  logic [31:0] s0_d_q, s0_r_q;
  logic [31:0] d_w, r_w;
  logic        beyond, outside;
  div_t        s1_q, s1_d;

  // classification of the incoming pixel
  always_comb begin
    d_w = sample_i - level_low_i;
    r_w = level_high_i - level_low_i;
    beyond = ({22'd0, column_i} >= VIEW_WIDTH) || ({22'd0, row_i} >= VIEW_HEIGHT);
    outside = outside_i || beyond;
    s0_side_d = '0;
    priority if (outside) begin
      s0_side_d.spec = 1'b1;
      s0_side_d.spec_idx = (column_i[0] ^ row_i[0]) ? CHECKER_IDX : 8'd0;
    end else if (blank_i || ($signed(sample_i) < $signed(level_low_i))) begin
      s0_side_d.spec = 1'b1;
      s0_side_d.spec_idx = 8'd0;
    end else if ($signed(sample_i) > $signed(level_high_i)) begin
      s0_side_d.spec = 1'b1;
      s0_side_d.spec_idx = IDX_MAX;
    end else begin
      s0_side_d.spec = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_side_q <= s0_side_d;
    s0_d_q    <= d_w;
    s0_r_q    <= r_w;
  end

  // top of window check and divider operands
  always_comb begin
    s1_d       = '0;
    s1_d.valid = s0_valid_q;
    s1_d.side  = s0_side_q;
    if (!s0_side_q.spec && (s0_d_q >= s0_r_q)) begin
      s1_d.side.spec = 1'b1;
      s1_d.side.spec_idx = IDX_MAX;
    end
    s1_d.r = s0_r_q;
    if (mode_i == MODE_LOG) begin
      s1_d.rem = (40'(s0_d_q) << 3) + 40'(s0_d_q);
    end else begin
      s1_d.rem = (40'(s0_d_q) << 8) - 40'(s0_d_q);
    end
    s1_d.rhs = 48'(s0_d_q) * 48'(SQRT_SCALE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  assign stage_o = s1_q;

endmodule

// ----- rtl/core/isp_divsqrt.sv -----
// pipelined restoring divider with the square root search alongside
module isp_divsqrt import isp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  div_t stage_i,
  output div_t stage_o
);

  div_t stg_q [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stg
    div_t cur, nxt;

    if (j == 0) begin : g_first
      assign cur = stage_i;
    end else begin : g_next
      assign cur = stg_q[j-1];
    end

    if (j < DIV_INT) begin : g_int
      logic [39:0] rsh;
      logic [15:0] t2;
      logic [47:0] prod;

      // one quotient bit and one root bit per integer stage
      always_comb begin
        nxt = cur;
        rsh = 40'(cur.r) << (DIV_INT - 1 - j);
        if (cur.rem >= rsh) begin
          nxt.rem = cur.rem - rsh;
          nxt.q[DIV_STAGES-1-j] = 1'b1;
        end
        t2 = cur.k2 + (16'(cur.side.sqrt_k) << (DIV_INT - j))
           + (16'd1 << (2 * (DIV_INT - 1 - j)));
        prod = 48'(t2) * 48'(cur.r);
        if (prod <= cur.rhs) begin
          nxt.side.sqrt_k[DIV_INT-1-j] = 1'b1;
          nxt.k2 = t2;
        end
      end
    end else begin : g_frac
      logic [39:0] rsh;

      // one fraction bit of the quotient per stage
      always_comb begin
        nxt = cur;
        rsh = {cur.rem[38:0], 1'b0};
        if (rsh >= 40'(cur.r)) begin
          nxt.rem = rsh - 40'(cur.r);
          nxt.q[DIV_STAGES-1-j] = 1'b1;
        end else begin
          nxt.rem = rsh;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_q[j] <= '0;
      end else begin
        stg_q[j] <= nxt;
      end
    end
  end

  assign stage_o = stg_q[DIV_STAGES-1];

endmodule

// ----- rtl/core/isp_log.sv -----
// log10 stretch: normalize, repeated squaring, coefficient multiply
module isp_log import isp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  div_t  stage_i,
  output coef_t stage_o
);

  log_t        norm_q, norm_d;
  log_t        sq_q [SQ_STAGES];
  coef_t       coef_q, coef_d;
  logic [33:0] x;
  logic [56:0] prod;

  // x = quotient + 1.0, split into exponent and mantissa
  always_comb begin
    x = stage_i.q + (34'd1 << FIX_FRAC);
    norm_d       = '0;
    norm_d.valid = stage_i.valid;
    norm_d.side  = stage_i.side;
    norm_d.lin   = stage_i.q[DIV_STAGES-1:FIX_FRAC];
    priority if (x[33:29] != 5'd0) begin
      norm_d.n = 2'd3;
    end else if (x[28]) begin
      norm_d.n = 2'd2;
    end else if (x[27]) begin
      norm_d.n = 2'd1;
    end else begin
      norm_d.n = 2'd0;
    end
    norm_d.m = 27'(x >> norm_d.n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q <= '0;
    end else begin
      norm_q <= norm_d;
    end
  end

  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sq
    log_t        cur, nxt;
    logic [53:0] sq;

    if (i == 0) begin : g_first
      assign cur = norm_q;
    end else begin : g_next
      assign cur = sq_q[i-1];
    end

    // one fraction bit of log2 per squaring
    always_comb begin
      nxt = cur;
      sq  = 54'(cur.m) * 54'(cur.m);
      nxt.frac[SQ_STAGES-1-i] = sq[53];
      nxt.m = sq[53] ? sq[53:27] : sq[52:26];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[i] <= '0;
      end else begin
        sq_q[i] <= nxt;
      end
    end
  end

  // scale log2 by 255*log10(2)
  always_comb begin
    prod = 57'({sq_q[SQ_STAGES-1].n, sq_q[SQ_STAGES-1].frac}) * 57'(LOG_COEF);
    coef_d.valid = sq_q[SQ_STAGES-1].valid;
    coef_d.side  = sq_q[SQ_STAGES-1].side;
    coef_d.lin   = sq_q[SQ_STAGES-1].lin;
    coef_d.lidx  = prod[56:48];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign stage_o = coef_q;

endmodule

// ----- tb/sv/tb_intensity_stretch_pixel_mapper.sv -----
// testbench of the intensity stretch pixel mapper: directed table plus random phases
module tb_intensity_stretch_pixel_mapper;
  import isp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] sample_i = '0;
  logic        blank_i = 1'b0;
  logic        outside_i = 1'b0;
  logic [9:0]  column_i = '0;
  logic [9:0]  row_i = '0;
  logic        result_valid_o;
  logic [7:0]  pixel_index_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  reg_idx_e    cfg_index_i = REG_LEVEL_LOW;
  logic [31:0] cfg_data_i = '0;

  intensity_stretch_pixel_mapper u_top (
    .clk_i, .rst_ni, .start, .busy, .sample_i, .blank_i, .outside_i, .column_i, .row_i,
    .result_valid_o, .pixel_index_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // register copy kept by the predictor
  logic [31:0] lvl_low = 32'd0;
  logic [31:0] lvl_high = 32'd65536;
  mode_e       cur_mode = MODE_LINEAR;
  logic        cur_reverse = 1'b0;

  logic [7:0]  index_queue[$];
  int          errors = 0;

  // typed expectation travelling with the pixel on the inputs
  logic        use_typed = 1'b0;
  logic [7:0]  typed_idx = '0;

  // floor square-root stretch: largest k with k*k*r <= 65025*d
  function automatic logic [7:0] sqrt_stretch(longint unsigned d, longint unsigned r);
    longint unsigned k, t, rhs;
    k = 0;
    rhs = 65025 * d;
    for (int b = 7; b >= 0; b--) begin
      t = k | (64'd1 << b);
      if (t * t * r <= rhs) k = t;
    end
    return k[7:0];
  endfunction

  // log10(9t+1) stretch through a fixed point log2
  function automatic logic [7:0] log_stretch(longint unsigned d, longint unsigned r);
    longint unsigned x, n, m, frac, res;
    x = ((9 * d + r) << 26) / r;
    n = 0;
    frac = 0;
    while (n < 3 && (x >> (n + 1)) >= (64'd1 << 26)) n++;
    m = x >> n;
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 26;
      frac = frac << 1;
      if (m >= (64'd1 << 27)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    res = (((n << 24) | frac) * 64'd1287863541) >> 48;
    if (res > 255) res = 255;
    return res[7:0];
  endfunction

  // expected display index of one pixel
  function automatic logic [7:0] map_pixel(logic [31:0] s, logic blk, logic outs,
                                           logic [9:0] col, logic [9:0] rw);
    longint v, lo, hi;
    longint unsigned d, r, lin;
    logic [7:0] idx;
    v = longint'($signed(s));
    lo = longint'($signed(lvl_low));
    hi = longint'($signed(lvl_high));
    if (outs || col >= VIEW_WIDTH_DEF || rw >= VIEW_HEIGHT_DEF) begin
      idx = (col[0] ^ rw[0]) ? CHECKER_IDX : 8'd0;
    end else if (blk || v < lo) begin
      idx = 8'd0;
    end else if (v > hi) begin
      idx = IDX_MAX;
    end else begin
      d = v - lo;
      r = hi - lo;
      if (d >= r) idx = IDX_MAX;
      else if (cur_mode == MODE_SQRT) idx = sqrt_stretch(d, r);
      else if (cur_mode == MODE_LOG) idx = log_stretch(d, r);
      else begin
        lin = (255 * d) / r;
        idx = lin[7:0];
      end
    end
    if (cur_reverse) idx = idx ^ REVERSE_MASK;
    return idx;
  endfunction

  // record accepted pixels, register writes and check results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        if (index_queue.size() == 0) begin
          $display("%0t: unexpected pixel_index %0d", $time, pixel_index_o);
          errors++;
        end else if (index_queue[0] !== pixel_index_o) begin
          $display("%0t: pixel_index expected %0d actual %0d", $time, index_queue[0],
                   pixel_index_o);
          errors++;
          void'(index_queue.pop_front());
        end else begin
          void'(index_queue.pop_front());
        end
      end
      if (start && !busy)
        index_queue.push_back(use_typed ? typed_idx
                              : map_pixel(sample_i, blank_i, outside_i, column_i, row_i));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_LEVEL_LOW:  lvl_low = cfg_data_i;
          REG_LEVEL_HIGH: lvl_high = cfg_data_i;
          REG_MODE:       cur_mode = mode_e'(cfg_data_i[1:0]);
          REG_REVERSE:    cur_reverse = cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // register write once the pipe has drained
  task automatic write_reg(reg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    start = 1'b0;
    while (index_queue.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_all(logic [31:0] lo, logic [31:0] hi, mode_e md, logic rev);
    write_reg(REG_LEVEL_LOW, lo);
    write_reg(REG_LEVEL_HIGH, hi);
    write_reg(REG_MODE, {30'd0, md});
    write_reg(REG_REVERSE, {31'd0, rev});
  endtask

  // one pixel transaction followed by an optional gap
  task automatic send_pixel(logic [31:0] s, logic blk, logic outs, logic [9:0] col,
                            logic [9:0] rw, logic typed, logic [7:0] exp_idx, int gap);
    @(negedge clk_i);
    start = 1'b1;
    sample_i = s;
    blank_i = blk;
    outside_i = outs;
    column_i = col;
    row_i = rw;
    use_typed = typed;
    typed_idx = exp_idx;
    do @(posedge clk_i); while (busy);
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic int pick_gap(bit quiet);
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // directed rows, typed values hold for the reset levels 0 and 1.0
  typedef struct {
    logic [31:0] s;
    logic        blk;
    logic        outs;
    logic [9:0]  col;
    logic [9:0]  rw;
    logic        typed;
    logic [7:0]  exp_idx;
  } pixel_row_t;

  pixel_row_t pixel_rows[] = '{
    '{32'h0000_8000, 1'b0, 1'b1, 10'd0,    10'd0,    1'b1, 8'd0},
    '{32'h0000_8000, 1'b0, 1'b1, 10'd1,    10'd0,    1'b1, 8'd30},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 10'd1023, 10'd1023, 1'b1, 8'd0},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 10'd1023, 10'd0,    1'b1, 8'd30},
    '{32'h0000_8000, 1'b1, 1'b0, 10'd5,    10'd7,    1'b1, 8'd0},
    '{32'h8000_0000, 1'b0, 1'b0, 10'd1023, 10'd1023, 1'b1, 8'd0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 10'd0,    10'd1023, 1'b1, 8'd255},
    '{32'h0001_0000, 1'b0, 1'b0, 10'd2,    10'd3,    1'b1, 8'd255},
    '{32'h0001_0001, 1'b0, 1'b0, 10'd2,    10'd3,    1'b1, 8'd255},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 10'd2,    10'd3,    1'b1, 8'd0},
    '{32'h0000_0000, 1'b0, 1'b0, 10'd9,    10'd4,    1'b1, 8'd0},
    '{32'h0000_0001, 1'b0, 1'b0, 10'd9,    10'd4,    1'b0, 8'd0},
    '{32'h0000_8000, 1'b0, 1'b0, 10'd9,    10'd4,    1'b0, 8'd0},
    '{32'h0000_FFFF, 1'b0, 1'b0, 10'd9,    10'd4,    1'b0, 8'd0},
    '{32'h0000_1234, 1'b0, 1'b0, 10'd512,  10'd511,  1'b0, 8'd0}
  };

  // random sample, mostly inside the display window
  function automatic logic [31:0] pick_sample();
    longint lo, hi;
    longint unsigned span;
    int p;
    lo = longint'($signed(lvl_low));
    hi = longint'($signed(lvl_high));
    p = $urandom_range(0, 9);
    if (p < 6 && hi > lo) begin
      span = hi - lo + 1;
      return 32'(lo + longint'({$urandom, $urandom} % span));
    end
    if (p == 6) begin
      case ($urandom_range(0, 3))
        0: return lvl_low;
        1: return lvl_high;
        2: return lvl_low - 32'd1;
        default: return lvl_high + 32'd1;
      endcase
    end
    return $urandom;
  endfunction

  // stimulus
  initial begin
    logic [31:0] lo, hi;
    bit quiet;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table under every mode, then reversed
    for (int md = 0; md < 5; md++) begin
      if (md == 4) write_reg(REG_REVERSE, 32'd1);
      else write_reg(REG_MODE, 32'(md));
      foreach (pixel_rows[i])
        send_pixel(pixel_rows[i].s, pixel_rows[i].blk, pixel_rows[i].outs,
                   pixel_rows[i].col, pixel_rows[i].rw, pixel_rows[i].typed,
                   pixel_rows[i].exp_idx ^ (md == 4 ? REVERSE_MASK : 8'd0),
                   pick_gap(1'b0));
    end

    // random phases over several level settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
        1: begin lo = $urandom; hi = lo; end
        2: begin lo = 32'h0010_0000; hi = 32'hFFF0_0000; end
        3: begin lo = 32'h7FFF_FFF0; hi = 32'h7FFF_FFFF; end
        4: begin lo = 32'h8000_0000; hi = 32'h8000_0003; end
        default: begin
          lo = $urandom;
          hi = $urandom;
          if ($signed(lo) > $signed(hi)) {lo, hi} = {hi, lo};
          if (lo == hi) hi = lo + 32'd1;
        end
      endcase
      write_all(lo, hi, mode_e'(2'(ph % 4)), ph[2] ^ ph[0]);
      quiet = (ph % 5 == 3);
      for (int i = 0; i < 160; i++)
        send_pixel(pick_sample(), $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0,
                   10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                   1'b0, 8'd0, pick_gap(quiet));
    end

    // drain
    @(negedge clk_i);
    start = 1'b0;
    while (index_queue.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (index_queue.size() != 0) errors++;
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
